/* src/der_env_pkg.sv */
// Shared types and codes for the DER envelope checker.
// No dependencies; imported by der_env_core, der_envelope_check_unit and the testbench.
package der_env_pkg;

  // Tag values accepted as the outer envelope
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_SET      = 8'h31;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] LF_BYTE      = 8'h0a;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_OCT  = 3'd2,
    PH_BODY = 3'd3,
    PH_SKIP = 3'd4
  } der_phase_e;

  typedef enum logic [2:0] {
    ST_EXACT    = 3'd0,
    ST_NEWLINE  = 3'd1,
    ST_BADTAG   = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_FORM     = 3'd4,
    ST_TOOBIG   = 3'd5,
    ST_MISMATCH = 3'd6
  } der_status_e;

  typedef struct packed {
    logic        accepted;
    der_status_e status;
    logic [31:0] declared_length;
    logic [2:0]  header_bytes;
  } der_verdict_t;

endpackage

/* src/der_envelope_check_unit.sv */
// Top level of the DER envelope checker: input word register, parse core,
// result register. Depends on der_env_pkg and der_env_core.
//
// Usage:
//   The slave channel carries one byte of a DER blob per word; tlast marks
//   the last byte of the blob. The first byte must be a SEQUENCE, SET or
//   OCTET STRING tag, followed by a short- or long-form length and content.
//   For every blob the master channel gives exactly one verdict word, after
//   the last byte; other bytes give no output.
//   Throughput: one byte per cycle, except while a last byte waits behind a
//   held verdict; the parse core updates its state on every byte taken.
//   Verdict path: the last byte passes the input register, then the result
//   register, which presents its verdict.
//   Stalls: a held verdict only blocks a further last byte; ordinary bytes
//   keep flowing into the parse state meanwhile.
//   Reset: asynchronous, active low; empties both registers and returns the
//   parser to expecting a tag byte. After each verdict the parser restarts.
module der_envelope_check_unit import der_env_pkg::*; #(
  parameter int MAX_LEN_OCTETS = 4,
  parameter int COUNT_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [3:1] status, [35:4] declared_length,
  // [38:36] header_bytes, [39] zero
  output logic [39:0] m_axis_tdata
);

  // input word register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_adv;

  // result register
  logic         out_vld_q;
  der_verdict_t out_q;
  logic         out_load;

  der_verdict_t verdict;
  der_phase_e   phase;
  logic [2:0]   hdr_cnt;
  logic         count_zero;

  // a last byte may move on only if the result register is empty or being read out
  assign in_adv   = in_vld_q && !(in_last_q && out_vld_q && !m_axis_tready);
  assign out_load = in_adv && in_last_q;
  assign s_axis_tready = !in_vld_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  der_env_core #(
    .MAX_LEN_OCTETS (MAX_LEN_OCTETS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (in_adv),
    .data_byte_i  (in_byte_q),
    .final_req_i  (in_last_q),
    .verdict_o    (verdict),
    .phase_o      (phase),
    .hdr_cnt_o    (hdr_cnt),
    .count_zero_o (count_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= verdict;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.header_bytes, out_q.declared_length,
                          out_q.status, out_q.accepted};

`ifndef NO_ASSERTIONS
  // verdict flag agrees with the status code
  a_accept_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ==
      (m_axis_tdata[3:1] == ST_EXACT || m_axis_tdata[3:1] == ST_NEWLINE)))
    else $error("accepted flag inconsistent with status");

  // a bad tag is seen on the first byte, with no length decoded
  a_badtag_hdr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3:1] == ST_BADTAG) |->
      (m_axis_tdata[38:36] == 3'd1 && m_axis_tdata[35:4] == 32'd0))
    else $error("bad tag verdict with header or length set");

  // waiting for a tag means nothing of the previous blob is left over
  a_clean_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase == PH_TAG) |-> (hdr_cnt == 3'd0 && count_zero))
    else $error("parse state not cleared at blob start");

  // a verdict is loaded only when the previous one is gone or taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("result register overwritten");
`endif

endmodule

/* src/der_env_core.sv */
// Per-blob parse state and verdict logic for the DER envelope checker.
// Depends on der_env_pkg.
module der_env_core import der_env_pkg::*; #(
  parameter int MAX_LEN_OCTETS = 4,
  parameter int COUNT_BITS     = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,      // consume one byte this cycle
  input  logic [7:0]   data_byte_i,
  input  logic         final_req_i,
  output der_verdict_t verdict_o,   // valid when take_i && final_req_i
  output der_phase_e   phase_o,
  output logic [2:0]   hdr_cnt_o,
  output logic         count_zero_o
);

  localparam int OLW = $clog2(MAX_LEN_OCTETS + 1);
  localparam int CNW = COUNT_BITS + 1;
  localparam int CMW = (CNW > 33) ? CNW : 33;

  der_phase_e    phase_q, phase_d;
  der_status_e   ferr_q, ferr_d;
  logic [OLW-1:0] oct_left_q, oct_left_d;
  logic [31:0]   length_q, length_d;
  logic [CNW-1:0] count_q, count_d;
  logic [2:0]    hdr_cnt_q, hdr_cnt_d;

  logic [6:0]    n_oct;
  logic [31:0]   len_v;
  logic [CMW-1:0] cnt_x, len_x;
  der_status_e   status;

  assign n_oct = data_byte_i[6:0];

  // next state after taking the byte
  always_comb begin
    phase_d    = phase_q;
    ferr_d     = ferr_q;
    oct_left_d = oct_left_q;
    length_d   = length_q;
    count_d    = count_q;
    hdr_cnt_d  = hdr_cnt_q;
    unique case (phase_q)
      PH_TAG: begin
        hdr_cnt_d = hdr_cnt_q + 3'd1;
        if (data_byte_i == TAG_SEQUENCE || data_byte_i == TAG_SET ||
            data_byte_i == TAG_OCTETS) begin
          phase_d = PH_LEN;
        end else begin
          ferr_d  = ST_BADTAG;
          phase_d = PH_SKIP;
        end
      end
      PH_LEN: begin
        hdr_cnt_d = hdr_cnt_q + 3'd1;
        if (!data_byte_i[7]) begin
          length_d = {24'd0, data_byte_i};
          phase_d  = PH_BODY;
        end else if (n_oct == 7'd0) begin
          ferr_d  = ST_FORM;
          phase_d = PH_SKIP;
        end else if (n_oct > 7'(MAX_LEN_OCTETS)) begin
          ferr_d  = ST_TOOBIG;
          phase_d = PH_SKIP;
        end else begin
          oct_left_d = n_oct[OLW-1:0];
          length_d   = '0;
          phase_d    = PH_OCT;
        end
      end
      PH_OCT: begin
        hdr_cnt_d = hdr_cnt_q + 3'd1;
        if (length_q[31:24] != 8'd0) begin
          ferr_d   = ST_TOOBIG;
          length_d = '0;
          phase_d  = PH_SKIP;
        end else begin
          length_d   = {length_q[23:0], data_byte_i};
          oct_left_d = oct_left_q - OLW'(1);
          if (oct_left_q == OLW'(1)) phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        // saturates at 2^COUNT_BITS (top bit set)
        if (!count_q[CNW-1]) count_d = count_q + CNW'(1);
      end
      default: begin
      end
    endcase
  end

  // verdict from the state after this byte
  assign len_v = (phase_d == PH_BODY) ? length_d : 32'd0;
  assign cnt_x = CMW'(count_d);
  assign len_x = CMW'(len_v);

  always_comb begin
    if (ferr_d != ST_EXACT) begin
      status = ferr_d;
    end else if (phase_d != PH_BODY) begin
      status = ST_TRUNC;
    end else if (cnt_x == len_x) begin
      status = ST_EXACT;
    end else if (cnt_x == len_x + CMW'(1) && data_byte_i == LF_BYTE) begin
      status = ST_NEWLINE;
    end else if (cnt_x < len_x) begin
      status = ST_TRUNC;
    end else begin
      status = ST_MISMATCH;
    end
  end

  assign verdict_o.accepted        = (status == ST_EXACT) || (status == ST_NEWLINE);
  assign verdict_o.status          = status;
  assign verdict_o.declared_length = len_v;
  assign verdict_o.header_bytes    = hdr_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG;
      ferr_q     <= ST_EXACT;
      oct_left_q <= '0;
      length_q   <= '0;
      count_q    <= '0;
      hdr_cnt_q  <= '0;
    end else if (take_i) begin
      if (final_req_i) begin
        phase_q    <= PH_TAG;
        ferr_q     <= ST_EXACT;
        oct_left_q <= '0;
        length_q   <= '0;
        count_q    <= '0;
        hdr_cnt_q  <= '0;
      end else begin
        phase_q    <= phase_d;
        ferr_q     <= ferr_d;
        oct_left_q <= oct_left_d;
        length_q   <= length_d;
        count_q    <= count_d;
        hdr_cnt_q  <= hdr_cnt_d;
      end
    end
  end

  assign phase_o      = phase_q;
  assign hdr_cnt_o    = hdr_cnt_q;
  assign count_zero_o = (count_q == '0);

endmodule

/* tb/sv/der_envelope_check_unit_tb.sv */
// Self-checking testbench for der_envelope_check_unit: streams DER blobs byte by byte and
// checks every verdict word against a cycle-free predictor held in this file.
// Depends on der_env_pkg and the der_envelope_check_unit RTL.
`timescale 1ns / 1ps

module der_envelope_check_unit_tb;
  import der_env_pkg::*;

  localparam int MAX_OCT      = 4;
  localparam int CNT_BITS     = 32;
  localparam int RANDOM_BYTES = 360;
  localparam int MIN_VERDICTS = 40;
  localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // final_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] accepted, [3:1] status, [35:4] declared_length,
  // [38:36] header_bytes, [39] zero
  logic [39:0] m_axis_tdata;

  der_envelope_check_unit #(
    .MAX_LEN_OCTETS(MAX_OCT),
    .COUNT_BITS    (CNT_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor. Mirrors the parse state; each accepted word advances
  // it, and a word with tlast set pushes one verdict and restarts the parse.
  // ---------------------------------------------------------------------------
  der_phase_e      parse_ph  = PH_TAG;
  der_status_e     err_code  = ST_EXACT;   // ST_EXACT here means no error latched
  int              oct_left  = 0;
  logic [31:0]     len_val   = '0;
  longint unsigned body_cnt  = 0;
  logic [7:0]      last_byte = '0;
  logic [2:0]      hdr_cnt   = '0;         // wraps, as the 3-bit field does

  der_verdict_t verdict_q[$];              // verdicts still owed by the block

  int errors        = 0;
  int bytes_sent    = 0;
  int verdicts_seen = 0;

  function automatic void envelope_restart();
    parse_ph  = PH_TAG;
    err_code  = ST_EXACT;
    oct_left  = 0;
    len_val   = '0;
    body_cnt  = 0;
    last_byte = '0;
    hdr_cnt   = '0;
  endfunction

  function automatic void envelope_take(input logic [7:0] b, input logic fin);
    der_verdict_t    v;
    der_status_e     st;
    longint unsigned decl;
    longint unsigned cap;
    cap = longint'(1) << CNT_BITS;
    case (parse_ph)
      PH_TAG: begin
        hdr_cnt++;
        if (b == TAG_SEQUENCE || b == TAG_SET || b == TAG_OCTETS) begin
          parse_ph = PH_LEN;
        end else begin
          err_code = ST_BADTAG;
          parse_ph = PH_SKIP;
        end
      end
      PH_LEN: begin
        hdr_cnt++;
        if (!b[7]) begin
          len_val  = 32'(b);
          parse_ph = PH_BODY;
        end else if (b[6:0] == 7'd0) begin
          err_code = ST_FORM;               // indefinite length
          parse_ph = PH_SKIP;
        end else if (int'(b[6:0]) > MAX_OCT) begin
          err_code = ST_TOOBIG;
          parse_ph = PH_SKIP;
        end else begin
          oct_left = int'(b[6:0]);
          len_val  = '0;
          parse_ph = PH_OCT;
        end
      end
      PH_OCT: begin
        hdr_cnt++;
        if (len_val[31:24] != 8'd0) begin
          err_code = ST_TOOBIG;             // next shift would overflow 32 bits
          len_val  = '0;
          parse_ph = PH_SKIP;
        end else begin
          len_val = {len_val[23:0], b};
          oct_left--;
          if (oct_left == 0) parse_ph = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_cnt < cap) body_cnt++;     // saturating content count
      end
      default: ;
    endcase
    last_byte = b;
    if (!fin) return;

    decl = (parse_ph == PH_BODY) ? longint'(len_val) : 0;
    // latched errors outrank truncation and size checks
    if (err_code != ST_EXACT)                           st = err_code;
    else if (parse_ph != PH_BODY)                       st = ST_TRUNC;
    else if (body_cnt == decl)                          st = ST_EXACT;
    else if (body_cnt == decl + 1 && last_byte == LF_BYTE) st = ST_NEWLINE;
    else if (body_cnt < decl)                           st = ST_TRUNC;
    else                                                st = ST_MISMATCH;

    v.accepted        = (st == ST_EXACT || st == ST_NEWLINE);
    v.status          = st;
    v.declared_length = decl[31:0];
    v.header_bytes    = hdr_cnt;
    verdict_q.push_back(v);
    envelope_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; gapless stretches on
  // request. Words are driven with NBAs just after a rising edge and counted
  // as accepted on the edge where tvalid and tready were both high.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit gapless    = 1'b0;

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);      // junk while idle, must be ignored
        s_axis_tlast  <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    envelope_take(b, last);
  endtask

  task automatic send_blob(input byte_q_t blob);
    foreach (blob[i]) send_byte(blob[i], i == blob.size() - 1);
  endtask

  // Pause the sender until every owed verdict has come back. Always waits
  // through a rising edge so tvalid is never dropped and raised in one step.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    burst_left = 0;
  endtask

  // Mostly well-formed envelopes with random content and lengths near the
  // declared one; the rest is noise, bad headers and cut-short blobs.
  function automatic byte_q_t make_blob();
    byte_q_t     q;
    int          pick, lsel, csel, dlen, body, n;
    logic [31:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
      return q;
    end
    if (pick < 12) q.push_back(8'($urandom));
    else begin
      case ($urandom_range(0, 2))
        0:       q.push_back(TAG_SEQUENCE);
        1:       q.push_back(TAG_SET);
        default: q.push_back(TAG_OCTETS);
      endcase
    end

    lsel = $urandom_range(0, 99);
    if (lsel < 45) begin
      dlen = $urandom_range(0, 12);
      q.push_back(8'(dlen));
    end else if (lsel < 55) begin
      dlen = $urandom_range(0, 127);
      q.push_back(8'(dlen));
    end else if (lsel < 85) begin
      n   = $urandom_range(1, MAX_OCT);
      val = ($urandom_range(0, 2) != 0) ? 32'($urandom_range(0, 12)) : 32'($urandom);
      if (n < 4) val &= (32'd1 << (8 * n)) - 32'd1;
      q.push_back(8'h80 | 8'(n));
      for (int i = n - 1; i >= 0; i--) q.push_back(8'(val >> (8 * i)));
      dlen = (val > 32'd64) ? 64 : int'(val);
    end else begin
      if (lsel < 90) q.push_back(8'h80);
      else if (lsel < 95) q.push_back(8'h80 | 8'($urandom_range(MAX_OCT + 1, 127)));
      else begin
        // long form cut short before all length octets are in
        n = $urandom_range(1, MAX_OCT);
        q.push_back(8'h80 | 8'(n));
        repeat ($urandom_range(0, n - 1)) q.push_back(8'($urandom));
        return q;
      end
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
      return q;
    end

    csel = $urandom_range(0, 99);
    if (csel < 50)      body = dlen;
    else if (csel < 75) body = dlen + 1;
    else if (csel < 88) body = (dlen == 0) ? 0 : $urandom_range(0, dlen - 1);
    else                body = dlen + $urandom_range(1, 4);
    if (body > 40) body = 40;                // big lengths end up truncated
    repeat (body) q.push_back(8'($urandom));
    if (csel >= 50 && csel < 65 && body != 0) q[q.size() - 1] = LF_BYTE;
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: tready follows a mode that is redrawn at random intervals, and
  // a long hold-off can be requested by a test.
  // ---------------------------------------------------------------------------
  bit long_hold_req = 1'b0;
  int rx_hold_left  = 0;
  int rx_mode_left  = 0;
  int rx_mode       = 0;

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold_left  = LONG_HOLD;
    end
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(16, 96);
      rx_mode      = $urandom_range(0, 3);
    end
    rx_mode_left--;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict checker: every accepted output word against the oldest owed one.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : verdict_check
    der_verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict word, expected none actual 0x%0h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(m_axis_tdata[0]));
        check_field("status", 32'(want.status), 32'(m_axis_tdata[3:1]));
        check_field("declared_length", want.declared_length, m_axis_tdata[35:4]);
        check_field("header_bytes", 32'(want.header_bytes), 32'(m_axis_tdata[38:36]));
        check_field("pad bit", 32'd0, 32'(m_axis_tdata[39]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_short_form();
    byte_q_t b;
    b = {TAG_SEQUENCE, 8'h00};                 send_blob(b);  // empty content
    b = {TAG_SET, 8'h01, 8'hAA};               send_blob(b);
    b = {TAG_OCTETS, 8'h00, LF_BYTE};          send_blob(b);  // newline surplus
    b = {TAG_SEQUENCE, 8'h7F};                 send_blob(b);  // largest short form
  endtask

  task automatic test_long_form();
    byte_q_t b;
    b = {TAG_SEQUENCE, 8'h84, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'hBB};
    send_blob(b);
    b = {TAG_SET, 8'h81, 8'h01, 8'hFF};        send_blob(b);
    // all-ones length: body never catches up
    b = {TAG_OCTETS, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_blob(b);
  endtask

  task automatic test_header_errors();
    byte_q_t b;
    b = {8'h00};                               send_blob(b);  // bad tag, lowest
    b = {8'hFF, 8'h01};                        send_blob(b);  // bad tag, highest
    b = {TAG_SEQUENCE, 8'h80, 8'h00};          send_blob(b);  // indefinite length
    b = {TAG_SEQUENCE, 8'h85};                 send_blob(b);  // too many octets
    b = {TAG_SEQUENCE};                        send_blob(b);  // header cut at tag
    b = {TAG_SET, 8'h82, 8'h00};               send_blob(b);  // cut in long form
  endtask

  task automatic test_content_count();
    byte_q_t b;
    b = {TAG_SEQUENCE, 8'h03, 8'h11};          send_blob(b);  // content short
    b = {TAG_OCTETS, 8'h01, 8'h11, 8'h22};     send_blob(b);  // surplus, no newline
  endtask

  // Receiver holds off while the sender keeps going, so a second last byte
  // backs up into the input; then the sender waits for everything to drain.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    gapless       = 1'b1;
    repeat (8) send_blob(make_blob());
    gapless = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_blobs();
    int byte_target, verdict_target;
    byte_target    = bytes_sent + RANDOM_BYTES;
    verdict_target = verdicts_seen + MIN_VERDICTS;
    while (bytes_sent < byte_target || verdicts_seen < verdict_target) begin
      gapless = ($urandom_range(0, 4) == 0);
      send_blob(make_blob());
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
    gapless = 1'b0;
  endtask

  // Watchdog
  int cycle_cnt = 0;
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_form();
    test_long_form();
    test_header_errors();
    test_content_count();
    wait_drain();
    test_backpressure();
    test_random_blobs();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
